### rtl/sfp_pkg.sv
// ---------------------------------------------------------------------------
// sfp_pkg
// Shared constants and codes for the sample frame parser.
// ---------------------------------------------------------------------------
package sfp_pkg;

    // Header layout
    localparam int HDR_LEN   = 10;
    localparam int HDR_IDX_W = 4;
    localparam int MIN_LEN   = 12;

    // Width of the shared compare unit: covers 10 + 2*count for any 8-bit count
    localparam int CMP_W = 10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_COUNT = 2'd2,
        ST_MISMATCH  = 2'd3
    } status_t;

endpackage

### rtl/sfp_if.sv
// ---------------------------------------------------------------------------
// sfp_if
// Valid/ready channels for frame bytes in and sample results out.
// ---------------------------------------------------------------------------
interface sfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       end_of_frame;

    modport source (output valid, output frame_byte, output end_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface sfp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         channel_id;
    logic [7:0]         boot_id;
    logic [7:0]         sequence_res;
    logic [31:0]        base_time_ms;
    logic [15:0]        interval_ms;
    logic [5:0]         sample_count;
    logic [4:0]         sample_index;
    logic signed [15:0] sample_value;
    logic               last_result;

    modport source (
        output valid, output status, output channel_id, output boot_id,
        output sequence_res, output base_time_ms, output interval_ms,
        output sample_count, output sample_index, output sample_value,
        output last_result, input ready
    );
    modport sink (
        input valid, input status, input channel_id, input boot_id,
        input sequence_res, input base_time_ms, input interval_ms,
        input sample_count, input sample_index, input sample_value,
        input last_result, output ready
    );
endinterface

### rtl/sfp_ram.sv
// ---------------------------------------------------------------------------
// sfp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module sfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/sample_frame_parser_core.sv
// Non-final bytes: one beat per cycle. A final byte is followed by up to four
// checks on the shared compare unit. Valid frame: each result takes a sample
// RAM read (S_RD) and an output load (S_LOAD), which waits for output space.
// Error frame: one result, loaded from S_ERR once the output is free. Input is
// blocked from the final beat until the last result is loaded. Reset is
// asynchronous; control clears at once, the sample RAM needs no clearing pass.
// ---------------------------------------------------------------------------
// sample_frame_parser_core
// Byte-serial sensor frame parser: header capture, sample store, length and
// count checks, and per-sample result emission.
// ---------------------------------------------------------------------------
module sample_frame_parser_core
    import sfp_pkg::*;
#(
    parameter int MAX_SAMPLES = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    sfp_in_if.sink         frames,
    sfp_out_if.source      results
);

    localparam int FRAME_MAX = HDR_LEN + 2 * MAX_SAMPLES;
    localparam int COUNT_SAT = FRAME_MAX + 1;
    localparam int CNT_W     = $clog2(COUNT_SAT + 1);
    localparam int IDX_W     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    typedef enum logic [7:0] {
        S_RECV      = 8'b0000_0001,
        S_CHK_LEN   = 8'b0000_0010,
        S_CHK_ZERO  = 8'b0000_0100,
        S_CHK_MAX   = 8'b0000_1000,
        S_CHK_MATCH = 8'b0001_0000,
        S_RD        = 8'b0010_0000,
        S_LOAD      = 8'b0100_0000,
        S_ERR       = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     byte_count_reg, byte_count_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    status_t              err_reg, err_next;
    logic [7:0]           low_byte_hold_reg;
    logic [7:0]           header_reg [HDR_LEN];

    logic                 in_fire;
    logic                 out_fire;
    logic                 out_space;
    logic [CNT_W-1:0]     pos;
    logic [CNT_W-1:0]     off;
    logic [CNT_W-1:0]     count_inc;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [15:0]          ram_rdata;

    logic [CMP_W-1:0]     cmp_a, cmp_b;
    logic                 cmp_lt, cmp_eq;

    logic                 load_ok, load_err;

    // Output register
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [7:0]           channel_id_reg, boot_id_reg, sequence_res_reg;
    logic [31:0]          base_time_ms_reg;
    logic [15:0]          interval_ms_reg;
    logic [5:0]           sample_count_reg;
    logic [4:0]           sample_index_reg;
    logic signed [15:0]   sample_value_reg;
    logic                 last_result_reg;

    assign frames.ready = (state_reg == S_RECV);
    assign in_fire      = frames.valid && frames.ready;
    assign out_fire     = results.valid && results.ready;
    assign out_space    = !out_valid_reg || results.ready;

    // Byte position bookkeeping
    assign pos       = byte_count_reg;
    assign off       = pos - CNT_W'(HDR_LEN);
    assign count_inc = (pos < CNT_W'(COUNT_SAT)) ? pos + 1'b1 : pos;

    assign ram_we    = in_fire && (pos < CNT_W'(FRAME_MAX)) && (pos >= CNT_W'(HDR_LEN))
                       && off[0];
    assign ram_waddr = IDX_W'(off >> 1);

    sfp_ram #(
        .WIDTH (16),
        .DEPTH (MAX_SAMPLES)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({frames.frame_byte, low_byte_hold_reg}),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Shared compare unit, operands picked by the sequencer
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (state_reg)
            S_CHK_LEN:
            begin
                cmp_a = CMP_W'(len_reg);
                cmp_b = CMP_W'(MIN_LEN);
            end
            S_CHK_ZERO:
            begin
                cmp_a = CMP_W'(header_reg[HDR_LEN-1]);
                cmp_b = CMP_W'(1);
            end
            S_CHK_MAX:
            begin
                cmp_a = CMP_W'(MAX_SAMPLES);
                cmp_b = CMP_W'(header_reg[HDR_LEN-1]);
            end
            S_CHK_MATCH:
            begin
                cmp_a = CMP_W'(len_reg);
                cmp_b = {1'b0, header_reg[HDR_LEN-1], 1'b0} + CMP_W'(HDR_LEN);
            end
            S_LOAD:
            begin
                cmp_a = CMP_W'(idx_reg) + 1'b1;
                cmp_b = CMP_W'(header_reg[HDR_LEN-1]);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);
    assign cmp_eq = (cmp_a == cmp_b);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        err_next        = err_reg;
        load_ok         = 1'b0;
        load_err        = 1'b0;
        unique case (state_reg)
            S_RECV:
            begin
                if (in_fire)
                begin
                    if (frames.end_of_frame)
                    begin
                        len_next        = count_inc;
                        byte_count_next = '0;
                        state_next      = S_CHK_LEN;
                    end
                    else
                    begin
                        byte_count_next = count_inc;
                    end
                end
            end
            S_CHK_LEN:
            begin
                if (cmp_lt)
                begin
                    err_next   = ST_SHORT;
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_CHK_ZERO;
                end
            end
            S_CHK_ZERO:
            begin
                if (cmp_lt)
                begin
                    err_next   = ST_BAD_COUNT;
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_CHK_MAX;
                end
            end
            S_CHK_MAX:
            begin
                if (cmp_lt)
                begin
                    err_next   = ST_BAD_COUNT;
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_CHK_MATCH;
                end
            end
            S_CHK_MATCH:
            begin
                if (!cmp_eq)
                begin
                    err_next   = ST_MISMATCH;
                    state_next = S_ERR;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold until the output register frees up
                if (out_space)
                begin
                    load_ok = 1'b1;
                    if (cmp_eq)
                    begin
                        state_next = S_RECV;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_ERR:
            begin
                if (out_space)
                begin
                    load_err   = 1'b1;
                    state_next = S_RECV;
                end
            end
            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_RECV;
            byte_count_reg    <= '0;
            len_reg           <= '0;
            idx_reg           <= '0;
            err_reg           <= ST_OK;
            low_byte_hold_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            err_reg        <= err_next;
            if (in_fire && (pos < CNT_W'(FRAME_MAX)) && (pos >= CNT_W'(HDR_LEN)) && !off[0])
            begin
                low_byte_hold_reg <= frames.frame_byte;
            end
            if (load_ok || load_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Header capture
    always_ff @(posedge clk)
    begin
        if (in_fire && (pos < CNT_W'(HDR_LEN)))
        begin
            header_reg[pos[HDR_IDX_W-1:0]] <= frames.frame_byte;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            status_reg       <= ST_OK;
            channel_id_reg   <= header_reg[0];
            boot_id_reg      <= header_reg[1];
            sequence_res_reg <= header_reg[2];
            base_time_ms_reg <= {header_reg[6], header_reg[5], header_reg[4], header_reg[3]};
            interval_ms_reg  <= {header_reg[8], header_reg[7]};
            sample_count_reg <= header_reg[9][5:0];
            sample_index_reg <= 5'(idx_reg);
            sample_value_reg <= $signed(ram_rdata);
            last_result_reg  <= cmp_eq;
        end
        else if (load_err)
        begin
            status_reg       <= err_reg;
            channel_id_reg   <= '0;
            boot_id_reg      <= '0;
            sequence_res_reg <= '0;
            base_time_ms_reg <= '0;
            interval_ms_reg  <= '0;
            sample_count_reg <= '0;
            sample_index_reg <= '0;
            sample_value_reg <= '0;
            last_result_reg  <= 1'b1;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.status       = status_reg;
    assign results.channel_id   = channel_id_reg;
    assign results.boot_id      = boot_id_reg;
    assign results.sequence_res = sequence_res_reg;
    assign results.base_time_ms = base_time_ms_reg;
    assign results.interval_ms  = interval_ms_reg;
    assign results.sample_count = sample_count_reg;
    assign results.sample_index = sample_index_reg;
    assign results.sample_value = sample_value_reg;
    assign results.last_result  = last_result_reg;

    // Checks
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.status != ST_OK)) |-> results.last_result)
        else $error("error result without last flag");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(COUNT_SAT))
        else $error("byte counter past saturation");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && frames.end_of_frame) |=> ((byte_count_reg == '0) && !frames.ready))
        else $error("frame end did not restart counter or block input");

    a_ram_wr_recv: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_RECV))
        else $error("sample store written outside receive");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives sample frames byte by byte into sample_frame_parser_core, predicts
// each per-sample or error result in step with accepted beats, and compares
// every returned result against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
    import sfp_pkg::*;

    localparam int MAX_SAMPLES = 32;
    localparam int FRAME_MAX   = HDR_LEN + 2 * MAX_SAMPLES;
    localparam int COUNT_SAT   = FRAME_MAX + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT    = 18;
    localparam int ITEM_GOAL   = 320;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZEROS,
        FILL_ONES,
        FILL_EXTREMES
    } fill_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  channel_id;
        logic [7:0]  boot_id;
        logic [7:0]  sequence_res;
        logic [31:0] base_time_ms;
        logic [15:0] interval_ms;
        logic [5:0]  sample_count;
        logic [4:0]  sample_index;
        logic [15:0] sample_value;
        logic        last_result;
    } sample_result_t;

    logic clk;
    logic rst_n;

    sfp_in_if  frames_if ();
    sfp_out_if results_if ();

    sample_frame_parser_core #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .frames (frames_if),
        .results(results_if)
    );

    // Predicted parser state
    int          frame_len;
    logic [7:0]  header_copy [HDR_LEN];
    logic [7:0]  low_hold;
    logic [15:0] sample_copy [MAX_SAMPLES];

    sample_result_t expected_results [$];
    logic [7:0]     frame_bytes [$];

    int beats_sent;
    int results_seen;
    int mismatch_count;
    int cycle_count;
    bit tx_quiet;
    bit rx_quiet;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Advance the predicted parser by one accepted byte
    function automatic void parse_byte(input logic [7:0] b, input logic eof);
        sample_result_t r;
        int             len;
        int             n;
        int             off;
        if (frame_len < FRAME_MAX)
        begin
            if (frame_len < HDR_LEN)
                header_copy[frame_len] = b;
            else
            begin
                off = frame_len - HDR_LEN;
                if (off % 2 == 0)
                    low_hold = b;
                else
                    sample_copy[off / 2] = {b, low_hold};
            end
        end
        if (frame_len < COUNT_SAT)
            frame_len++;
        if (!eof)
            return;

        len       = frame_len;
        frame_len = 0;
        r             = '0;
        r.last_result = 1'b1;
        n             = header_copy[9];
        if (len < MIN_LEN)
        begin
            r.status = ST_SHORT;
            expected_results.push_back(r);
        end
        else if (n == 0 || n > MAX_SAMPLES)
        begin
            r.status = ST_BAD_COUNT;
            expected_results.push_back(r);
        end
        else if (len != HDR_LEN + 2 * n)
        begin
            r.status = ST_MISMATCH;
            expected_results.push_back(r);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                r.status       = ST_OK;
                r.channel_id   = header_copy[0];
                r.boot_id      = header_copy[1];
                r.sequence_res = header_copy[2];
                r.base_time_ms = {header_copy[6], header_copy[5], header_copy[4],
                                  header_copy[3]};
                r.interval_ms  = {header_copy[8], header_copy[7]};
                r.sample_count = header_copy[9][5:0];
                r.sample_index = i[4:0];
                r.sample_value = sample_copy[i];
                r.last_result  = (i == n - 1);
                expected_results.push_back(r);
            end
        end
    endfunction

    function automatic string describe(input sample_result_t r);
        return $sformatf({"status=%0d ch=%h boot=%h seq=%h time=%h intv=%h cnt=%0d ",
                          "idx=%0d val=%h last=%b"},
                         r.status, r.channel_id, r.boot_id, r.sequence_res,
                         r.base_time_ms, r.interval_ms, r.sample_count,
                         r.sample_index, r.sample_value, r.last_result);
    endfunction

    function automatic void check_result(input sample_result_t got);
        sample_result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: %s", describe(got));
            return;
        end
        want = expected_results.pop_front();
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("result mismatch at cycle %0d", cycle_count);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        end
    endfunction

    // Send one beat after a random gap; predict at acceptance
    task automatic send_beat(input logic [7:0] b, input logic eof);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            frames_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frames_if.valid        <= 1'b1;
        frames_if.frame_byte   <= b;
        frames_if.end_of_frame <= eof;
        do
            @(posedge clk);
        while (!frames_if.ready);
        parse_byte(b, eof);
        beats_sent++;
    endtask

    // Build a frame of len bytes with count byte at header position 9, then send it
    task automatic send_frame(input fill_t fill, input logic [7:0] count_byte, input int len);
        int j;
        frame_bytes.delete();
        for (int k = 0; k < len; k++)
        begin
            j = (k - HDR_LEN) / 2;
            case (fill)
                FILL_ZEROS: frame_bytes.push_back(8'h00);
                FILL_ONES:  frame_bytes.push_back(8'hFF);
                FILL_EXTREMES:
                    if (k < HDR_LEN)
                        frame_bytes.push_back(8'($urandom));
                    else if ((k - HDR_LEN) % 2 == 0)
                        frame_bytes.push_back((j % 2 == 0) ? 8'hFF : 8'h00);
                    else
                        frame_bytes.push_back((j % 2 == 0) ? 8'h7F : 8'h80);
                default:    frame_bytes.push_back(8'($urandom));
            endcase
        end
        if (len > 9)
            frame_bytes[9] = count_byte;
        for (int k = 0; k < len; k++)
            send_beat(frame_bytes[k], k == len - 1);
    endtask

    task automatic send_valid_frame(input fill_t fill, input int n);
        send_frame(fill, 8'(n), HDR_LEN + 2 * n);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic wait_all_results;
        frames_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_short_frames;
        send_frame(FILL_RANDOM, 8'h01, 1);
        send_frame(FILL_ONES, 8'h01, 11);
    endtask

    task automatic test_bad_count;
        send_frame(FILL_ZEROS, 8'h00, 12);
        send_frame(FILL_RANDOM, 8'(MAX_SAMPLES + 1), 12);
    endtask

    task automatic test_length_mismatch;
        send_frame(FILL_RANDOM, 8'd2, 12);
        send_frame(FILL_RANDOM, 8'd1, 13);
    endtask

    task automatic test_valid_frames;
        send_valid_frame(FILL_ZEROS, 1);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_valid_frame(FILL_EXTREMES, MAX_SAMPLES);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_overlong_frames;
        // counter saturates; surplus bytes must not disturb the next frame
        send_frame(FILL_RANDOM, 8'(MAX_SAMPLES), FRAME_MAX + 3);
        send_valid_frame(FILL_RANDOM, 1);
    endtask

    task automatic test_drained_sender;
        send_valid_frame(FILL_RANDOM, 2);
        wait_all_results();
        send_valid_frame(FILL_RANDOM, 1);
        wait_all_results();
    endtask

    task automatic test_random_traffic;
        int kind;
        int n;
        int len;
        int frames_done;
        frames_done = 0;
        while (beats_sent < ITEM_GOAL)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_SAMPLES)
                                            : $urandom_range(1, 4);
            if (kind < 70)
                send_valid_frame(FILL_RANDOM, n);
            else if (kind < 78)
                send_frame(FILL_RANDOM, 8'($urandom), $urandom_range(1, MIN_LEN - 1));
            else if (kind < 86)
                send_frame(FILL_RANDOM,
                           $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(33, 255)),
                           $urandom_range(MIN_LEN, 24));
            else if (kind < 94)
            begin
                len = $urandom_range(MIN_LEN, HDR_LEN + 2 * n + 6);
                if (len == HDR_LEN + 2 * n)
                    len++;
                send_frame(FILL_RANDOM, 8'(n), len);
            end
            else
                send_frame(FILL_RANDOM, 8'($urandom), $urandom_range(FRAME_MAX + 1, 100));
            frames_done++;
            if (frames_done % 10 == 0)
                wait_all_results();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Result sink: random stalls, check every accepted beat
    initial
    begin
        int             stall;
        sample_result_t got;
        results_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!results_if.valid);
            got.status       = status_t'(results_if.status);
            got.channel_id   = results_if.channel_id;
            got.boot_id      = results_if.boot_id;
            got.sequence_res = results_if.sequence_res;
            got.base_time_ms = results_if.base_time_ms;
            got.interval_ms  = results_if.interval_ms;
            got.sample_count = results_if.sample_count;
            got.sample_index = results_if.sample_index;
            got.sample_value = results_if.sample_value;
            got.last_result  = results_if.last_result;
            check_result(got);
        end
    end

    initial
    begin
        beats_sent     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        frame_len      = 0;
        low_hold       = '0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        rst_n                  <= 1'b0;
        frames_if.valid        <= 1'b0;
        frames_if.frame_byte   <= '0;
        frames_if.end_of_frame <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_bad_count();
        test_length_mismatch();
        test_valid_frames();
        test_overlong_frames();
        test_drained_sender();
        test_random_traffic();

        wait_all_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
